// ===== hdl/hse_pkg.sv =====
// shared constants, types and helpers for the heap sort engine
// no dependencies

package hse_pkg;

  localparam int MAX_ITEMS   = 64;
  localparam int VALUE_WIDTH = 32;
  localparam int ADDR_W      = $clog2(MAX_ITEMS);
  localparam int IDX_W       = $clog2(MAX_ITEMS + 1);
  localparam int CHILD_W     = IDX_W + 1;

  typedef logic signed [VALUE_WIDTH-1:0] value_t;
  typedef logic [IDX_W-1:0]              idx_t;
  typedef logic [ADDR_W-1:0]             addr_t;

  typedef enum logic [3:0] {
    S_LOAD,
    S_BLD_INIT,
    S_LDV,
    S_LDV2,
    S_SL,
    S_SR,
    S_SC,
    S_SW,
    S_EX0,
    S_EX1,
    S_EX2,
    S_ORD,
    S_OCAP,
    S_OHOLD
  } state_t;

  typedef enum logic {
    M_BUILD,
    M_EXTRACT
  } mode_t;

  // one-based heap position to store address
  function automatic addr_t idx2addr(idx_t idx);
    idx_t m1;
    m1 = idx - IDX_W'(1);
    return m1[ADDR_W-1:0];
  endfunction

endpackage

// ===== hdl/heap_sort_engine_core.sv =====
// heap sort engine top level: load, heap build, extraction and output sequencer
// depends on hse_pkg and hse_ram

// Values of a set are taken one per cycle and written into a one-based heap store
// of MAX_ITEMS entries; items beyond that are dropped and reported on out_overflow.
// The request carrying in_last starts the sort; no input is taken until the last
// sorted value has been delivered. The store is a single ram with one write and one
// registered read port, so each sift-down level reads the left child, then the right
// child, then compares and writes back; a sift that runs out of children ends with a
// write of the held value, each heap-build node first loads its value, each
// extraction reads the root and the last leaf and swaps them, and each result is read
// from the store before it is shown. Sort time grows as n*log2(n).

module heap_sort_engine_core
  import hse_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_stall,
  input  value_t in_value,
  input  logic   in_last,
  output logic   out_valid,
  input  logic   out_stall,
  output value_t out_value,
  output logic   out_last,
  output logic   out_overflow
);

  state_t state_r, state_nxt;
  mode_t  mode_r, mode_nxt;
  idx_t   count_r, count_nxt;
  logic   dropped_r, dropped_nxt;
  idx_t   i_r, i_nxt;
  idx_t   node_r, node_nxt;
  idx_t   lim_r, lim_nxt;
  idx_t   o_idx_r, o_idx_nxt;
  value_t v_r, v_nxt;
  value_t lval_r, lval_nxt;
  logic   out_valid_r, out_valid_nxt;
  value_t out_value_r, out_value_nxt;
  logic   out_last_r, out_last_nxt;
  logic   out_ovf_r, out_ovf_nxt;

  logic   ram_we;
  addr_t  ram_waddr;
  value_t ram_wdata;
  addr_t  ram_raddr;
  logic [VALUE_WIDTH-1:0] ram_rdata;
  value_t rd_val;

  logic               in_acc, out_acc, store_ok;
  idx_t               half;
  idx_t               o_next;
  logic [CHILD_W-1:0] l_w, r_w, lim_ext, l_m1, big_sel;
  addr_t              l_addr, r_addr;
  logic               l_over, r_ok, left_ge, right_ge, big_is_node, sift_end;
  value_t             big_a_val, big_val;
  idx_t               big_idx;

  hse_ram #(
    .DEPTH(MAX_ITEMS),
    .WIDTH(VALUE_WIDTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign rd_val = ram_rdata;

  assign in_stall = (state_r != S_LOAD);
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid_r && !out_stall;
  assign store_ok = (count_r < IDX_W'(MAX_ITEMS));
  assign half     = count_r >> 1;
  assign o_next   = o_idx_r + IDX_W'(1);

  // child positions of the current node
  assign l_w     = {node_r, 1'b0};
  assign r_w     = {node_r, 1'b1};
  assign lim_ext = {1'b0, lim_r};
  assign l_m1    = l_w - CHILD_W'(1);
  assign l_addr  = l_m1[ADDR_W-1:0];
  assign r_addr  = l_w[ADDR_W-1:0];
  assign l_over  = (l_w > lim_ext);
  assign r_ok    = (r_w <= lim_ext);

  // pick the larger of node, left and right, children win ties
  assign left_ge     = (lval_r >= v_r);
  assign big_a_val   = left_ge ? lval_r : v_r;
  assign right_ge    = r_ok && (rd_val >= big_a_val);
  assign big_val     = right_ge ? rd_val : big_a_val;
  assign big_is_node = !left_ge && !right_ge;
  assign big_sel     = right_ge ? r_w : l_w;
  assign big_idx     = big_sel[IDX_W-1:0];

  assign sift_end = (state_r == S_SW) || ((state_r == S_SC) && big_is_node);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_LOAD: begin
        if (in_acc && in_last) state_nxt = S_BLD_INIT;
      end
      S_BLD_INIT: begin
        state_nxt = (half == '0) ? S_ORD : S_LDV;
      end
      S_LDV:  state_nxt = S_LDV2;
      S_LDV2: state_nxt = S_SL;
      S_SL: begin
        state_nxt = l_over ? S_SW : S_SR;
      end
      S_SR: state_nxt = S_SC;
      S_SC, S_SW: begin
        if (state_r == S_SC && !big_is_node) begin
          state_nxt = S_SL;
        end else if (mode_r == M_BUILD) begin
          state_nxt = (i_r == IDX_W'(1)) ? S_EX0 : S_LDV;
        end else begin
          state_nxt = (i_r == IDX_W'(2)) ? S_ORD : S_EX0;
        end
      end
      S_EX0:  state_nxt = S_EX1;
      S_EX1:  state_nxt = S_EX2;
      S_EX2:  state_nxt = S_SL;
      S_ORD:  state_nxt = S_OCAP;
      S_OCAP: state_nxt = S_OHOLD;
      S_OHOLD: begin
        if (out_acc) state_nxt = out_last_r ? S_LOAD : S_OCAP;
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  // datapath, store access and output register updates
  always_comb begin
    mode_nxt      = mode_r;
    count_nxt     = count_r;
    dropped_nxt   = dropped_r;
    i_nxt         = i_r;
    node_nxt      = node_r;
    lim_nxt       = lim_r;
    o_idx_nxt     = o_idx_r;
    v_nxt         = v_r;
    lval_nxt      = lval_r;
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '0;
    ram_raddr     = '0;
    case (state_r)
      S_LOAD: begin
        o_idx_nxt = IDX_W'(1);
        if (in_acc) begin
          if (store_ok) begin
            ram_we    = 1'b1;
            ram_waddr = count_r[ADDR_W-1:0];
            ram_wdata = in_value;
            count_nxt = count_r + IDX_W'(1);
          end else begin
            dropped_nxt = 1'b1;
          end
        end
      end
      S_BLD_INIT: begin
        mode_nxt = M_BUILD;
        i_nxt    = half;
      end
      S_LDV: begin
        ram_raddr = idx2addr(i_r);
        node_nxt  = i_r;
        lim_nxt   = count_r;
      end
      S_LDV2: begin
        v_nxt = rd_val;
      end
      S_SL: begin
        ram_raddr = l_addr;
      end
      S_SR: begin
        lval_nxt  = rd_val;
        ram_raddr = r_addr;
      end
      S_SC, S_SW: begin
        ram_we    = 1'b1;
        ram_waddr = idx2addr(node_r);
        if (state_r == S_SC && !big_is_node) begin
          ram_wdata = big_val;
          node_nxt  = big_idx;
        end else begin
          ram_wdata = v_r;
          if (mode_r == M_BUILD) begin
            if (i_r == IDX_W'(1)) begin
              mode_nxt = M_EXTRACT;
              i_nxt    = count_r;
            end else begin
              i_nxt = i_r - IDX_W'(1);
            end
          end else if (i_r != IDX_W'(2)) begin
            i_nxt = i_r - IDX_W'(1);
          end
        end
      end
      S_EX0: begin
        ram_raddr = idx2addr(IDX_W'(1));
      end
      S_EX1: begin
        lval_nxt  = rd_val;
        ram_raddr = idx2addr(i_r);
      end
      S_EX2: begin
        v_nxt     = rd_val;
        ram_we    = 1'b1;
        ram_waddr = idx2addr(i_r);
        ram_wdata = lval_r;
        node_nxt  = IDX_W'(1);
        lim_nxt   = i_r - IDX_W'(1);
      end
      S_ORD: begin
        ram_raddr = idx2addr(o_idx_r);
      end
      S_OCAP: begin
        out_valid_nxt = 1'b1;
        out_value_nxt = rd_val;
        out_last_nxt  = (o_idx_r == count_r);
        out_ovf_nxt   = dropped_r;
      end
      S_OHOLD: begin
        if (out_acc) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            count_nxt   = '0;
            dropped_nxt = 1'b0;
          end else begin
            o_idx_nxt = o_next;
            ram_raddr = idx2addr(o_next);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      mode_r      <= M_BUILD;
      count_r     <= '0;
      dropped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      count_r     <= count_nxt;
      dropped_r   <= dropped_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r         <= i_nxt;
    node_r      <= node_nxt;
    lim_r       <= lim_nxt;
    o_idx_r     <= o_idx_nxt;
    v_r         <= v_nxt;
    lval_r      <= lval_nxt;
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_value    = out_value_r;
  assign out_last     = out_last_r;
  assign out_overflow = out_ovf_r;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= IDX_W'(MAX_ITEMS))
    else $error("element count beyond store depth");

  a_sift_node: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SL) |-> (node_r != '0) && (node_r <= lim_r))
    else $error("sift node outside the live heap");

  a_out_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_OHOLD))
    else $error("result shown outside output hold");

  a_set_close: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_last_r) |=> (count_r == '0) && !dropped_r && (state_r == S_LOAD))
    else $error("set not cleared after final result");
`endif

endmodule

// ===== hdl/hse_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies

module hse_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== dv/tb.sv =====
// self-checking testbench for heap_sort_engine_core: sends sets of signed values and
// checks every sorted result against an in-bench sorting predictor
// depends on hse_pkg and the heap sort engine rtl

module tb;
  import hse_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int     CYCLE_LIMIT  = 400000;
  localparam int     RANDOM_ITEMS = 110;
  localparam value_t V_MIN        = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
  localparam value_t V_MAX        = ~V_MIN;

  typedef enum {V_ANY, V_NARROW, V_EDGE} value_mix_t;

  typedef struct {
    value_t value;
    logic   last;
    logic   overflow;
  } sorted_entry_t;

  logic   clk       = 1'b0;
  logic   rst_n     = 1'b0;
  logic   in_valid  = 1'b0;
  logic   in_stall;
  value_t in_value  = '0;
  logic   in_last   = 1'b0;
  logic   out_valid;
  logic   out_stall = 1'b0;
  value_t out_value;
  logic   out_last;
  logic   out_overflow;

  value_t        held_vals[$];
  logic          set_dropped = 1'b0;
  sorted_entry_t ascending_q[$];
  sorted_entry_t want;
  int            errors      = 0;
  int            cycle_count = 0;
  int            stall_left  = 0;
  bit            steady      = 1'b0;

  heap_sort_engine_core dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_value     (in_value),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_value    (out_value),
    .out_last     (out_last),
    .out_overflow (out_overflow)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  function automatic value_t pick_value(value_mix_t mix);
    case (mix)
      V_NARROW: return value_t'(int'($urandom_range(0, 8)) - 4);
      V_EDGE: begin
        case ($urandom_range(0, 5))
          0: return V_MIN;
          1: return V_MAX;
          2: return V_MIN + 1;
          3: return V_MAX - 1;
          4: return '0;
          default: return '1;
        endcase
      end
      default: return value_t'($urandom);
    endcase
  endfunction

  // store model: full store drops the request, the closing request sorts what is held
  task automatic take_value(value_t v, logic last);
    value_t run[$];
    value_t key;
    int     j;
    if (held_vals.size() < MAX_ITEMS) held_vals.push_back(v);
    else set_dropped = 1'b1;
    if (last) begin
      run = held_vals;
      for (int i = 1; i < run.size(); i++) begin
        key = run[i];
        j = i - 1;
        while (j >= 0 && run[j] > key) begin
          run[j+1] = run[j];
          j--;
        end
        run[j+1] = key;
      end
      for (int i = 0; i < run.size(); i++) begin
        ascending_q.push_back('{run[i], logic'(i == run.size() - 1), set_dropped});
      end
      held_vals.delete();
      set_dropped = 1'b0;
    end
  endtask

  task automatic send_value(value_t v, logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    in_last  <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    take_value(v, last);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (ascending_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_single_values();
    send_value(V_MIN, 1'b1);
    send_value(V_MAX, 1'b1);
    send_value('0, 1'b1);
    send_value('1, 1'b1);
    wait_drained();
  endtask

  task automatic test_small_sets();
    send_value(V_MAX, 1'b0);
    send_value(V_MIN, 1'b0);
    send_value('0, 1'b0);
    send_value('1, 1'b0);
    send_value(value_t'(1), 1'b1);
    // equal keys
    send_value(value_t'(5), 1'b0);
    send_value(value_t'(5), 1'b0);
    send_value(value_t'(5), 1'b1);
    send_value(value_t'(7), 1'b0);
    send_value(value_t'(-7), 1'b1);
    for (int i = 1; i <= 4; i++) send_value(value_t'(i), logic'(i == 4));
    wait_drained();
  endtask

  task automatic test_full_store();
    for (int i = 0; i < MAX_ITEMS; i++) begin
      send_value(value_t'(MAX_ITEMS - 2 * i), logic'(i == MAX_ITEMS - 1));
    end
    wait_drained();
  endtask

  // extra requests, the closing one among them, are dropped
  task automatic test_overflow();
    for (int i = 0; i < MAX_ITEMS + 2; i++) begin
      send_value(pick_value(V_ANY), logic'(i == MAX_ITEMS + 1));
    end
    send_value(value_t'(3), 1'b0);
    send_value(value_t'(-3), 1'b1);
    wait_drained();
  endtask

  task automatic test_random_sets();
    int         sent;
    int         size;
    int         r;
    value_mix_t mix;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 80) size = $urandom_range(1, 12);
      else if (r < 95) size = $urandom_range(13, 40);
      else size = $urandom_range(41, MAX_ITEMS + 6);
      mix    = value_mix_t'($urandom_range(0, 2));
      steady = ($urandom_range(0, 4) == 0);
      for (int k = 0; k < size; k++) send_value(pick_value(mix), logic'(k == size - 1));
      sent += size;
      if ($urandom_range(0, 9) == 0) wait_drained();
    end
    steady = 1'b0;
    wait_drained();
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall  <= 1'b0;
      stall_left <= pick_gap();
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (ascending_q.size() == 0) begin
        $display("%0t: unexpected result, expected none got value %0d last %0b overflow %0b",
                 $time, out_value, out_last, out_overflow);
        errors++;
      end else begin
        want = ascending_q.pop_front();
        if (out_value !== want.value) begin
          $display("%0t: out_value expected %0d got %0d", $time, want.value, out_value);
          errors++;
        end
        if (out_last !== want.last) begin
          $display("%0t: out_last expected %0b got %0b", $time, want.last, out_last);
          errors++;
        end
        if (out_overflow !== want.overflow) begin
          $display("%0t: out_overflow expected %0b got %0b", $time, want.overflow,
                   out_overflow);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_single_values();
    test_small_sets();
    test_full_store();
    test_overflow();
    test_random_sets();
    repeat (100) @(posedge clk);
    if (errors == 0 && ascending_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
